@@ sv/assert_macros.svh @@
// Assertion helpers shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, switched off while reset is held.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ sv/avtplc_pkg.sv @@
package avtplc_pkg;

  // Field widths of the packet header summary and of the result.
  localparam int FRAME_W   = 11;
  localparam int COUNTER_W = 8;
  localparam int LEN_W     = 16;
  localparam int TIME_W    = 32;
  localparam int SAMPLE_W  = 14;
  localparam int WANT_W    = 7;
  localparam int STATUS_W  = 3;
  localparam int LOCK_W    = 4;

  // Step counter of the divider, wide enough for SAMPLE_W steps.
  localparam int DIV_CNT_W = 4;

  // Stream bus widths.
  localparam int IN_TDATA_W  = 72;
  localparam int IN_TUSER_W  = 4;
  localparam int OUT_TDATA_W = 80;
  localparam int OUT_TUSER_W = 5;

  // Ethernet header length with and without a VLAN tag.
  localparam int VLAN_HDR_BYTES  = 18;
  localparam int PLAIN_HDR_BYTES = 14;

  // Bytes of the data length that precede the first audio quadlet.
  localparam int CIP_DATA_OFFSET = 8;

  // Timestamps are registered on every eighth data block.
  localparam int STAMP_PHASE_W = 3;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 3'd0,
    STATUS_TOO_SHORT = 3'd1,
    STATUS_CONTROL   = 3'd2,
    STATUS_NO_STREAM = 3'd3,
    STATUS_LOCKING   = 3'd4
  } status_t;

  // Request to the divider.
  typedef struct packed {
    logic                 start;
    logic [SAMPLE_W-1:0]  dividend;
    logic [COUNTER_W-1:0] divisor;
  } div_req_t;

  // Answer from the divider.
  typedef struct packed {
    logic                done;
    logic [SAMPLE_W-1:0] quotient;
  } div_result_t;

endpackage

@@ sv/avtplc_divider.sv @@
module avtplc_divider (
  input  logic                   clk,
  input  logic                   rst_n,
  input  avtplc_pkg::div_req_t    req,
  output avtplc_pkg::div_result_t result
);

  localparam int DEND_W = avtplc_pkg::SAMPLE_W;
  localparam int DSOR_W = avtplc_pkg::COUNTER_W;
  localparam int CNT_W  = avtplc_pkg::DIV_CNT_W;
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DEND_W - 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [DEND_W-1:0] quot_r, quot_nxt;
  logic [DSOR_W-1:0] rem_r, rem_nxt;
  logic [DSOR_W-1:0] divisor_r, divisor_nxt;
  logic [DSOR_W:0]   trial;
  logic              fits;

  // One restoring step per cycle: shift in the next dividend bit and
  // subtract the divisor where it fits.
  always_comb begin
    trial     = {rem_r, quot_r[DEND_W-1]};
    fits      = trial >= {1'b0, divisor_r};
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    count_nxt = count_r;
    quot_nxt  = quot_r;
    rem_nxt   = rem_r;
    divisor_nxt = divisor_r;
    if (req.start) begin
      busy_nxt    = 1'b1;
      count_nxt   = '0;
      quot_nxt    = req.dividend;
      rem_nxt     = '0;
      divisor_nxt = req.divisor;
    end else if (busy_r) begin
      rem_nxt   = fits ? DSOR_W'(trial - {1'b0, divisor_r}) : trial[DSOR_W-1:0];
      quot_nxt  = {quot_r[DEND_W-2:0], fits};
      count_nxt = count_r + 1'b1;
      if (count_r == LAST_STEP) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    count_r   <= count_nxt;
    quot_r    <= quot_nxt;
    rem_r     <= rem_nxt;
    divisor_r <= divisor_nxt;
  end

  assign result.done     = done_r;
  assign result.quotient = quot_r;

endmodule

@@ sv/avtp_listener_packet_check.sv @@
// Audio stream listener packet check.
// The input channel carries one beat per received packet: the header fields
// that a parser has already pulled out of the frame. The result channel
// carries one beat per input beat, in order: whether samples are to be
// delivered, a status code, the timestamp to register and the channel,
// stride and sample counts for the sample FIFOs.
// cfg_wr_en with cfg_wr_data sets the number of wanted output channels; the
// user must write it only while idle, which the block does not enforce.
// A packet that is rejected, or handled without a division, passes from the
// evaluation state to the finish state, which fills the output register
// when it is free and returns to idle. While locking with nonzero previous
// samples and counter difference, a division state comes in between, where
// a restoring divider gives the channel count, one quotient bit per cycle.
// in_tready is high only while no packet is under evaluation.
// A finished result sits in the output register; the next packet is
// accepted and evaluated meanwhile, and its result waits until the
// receiver takes the earlier beat.
// Reset clears the lock state, the stored counter and sample count, the
// wanted channel count and out_tvalid, and sets in_tready by going idle.
module avtp_listener_packet_check #(
  parameter int STREAM_HEADER_BYTES = 24,
  parameter int CIP_HEADER_BYTES    = 8,
  parameter int LOCK_THRESHOLD      = 10
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [avtplc_pkg::WANT_W-1:0]      cfg_wr_data,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // frame_bytes, block_counter, data_length, presentation_time, zero fill
  input  logic [avtplc_pkg::IN_TDATA_W-1:0]  in_tdata,
  // vlan_tagged, control_flag, stream_id_valid, time_valid
  input  logic [avtplc_pkg::IN_TUSER_W-1:0]  in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // stamp_value, push_channels, push_stride, push_samples, zero fill
  output logic [avtplc_pkg::OUT_TDATA_W-1:0] out_tdata,
  // accepted, status, stamp_now
  output logic [avtplc_pkg::OUT_TUSER_W-1:0] out_tuser
);

  localparam int FW = avtplc_pkg::FRAME_W;
  localparam int CW = avtplc_pkg::COUNTER_W;
  localparam int LW = avtplc_pkg::LEN_W;
  localparam int TW = avtplc_pkg::TIME_W;
  localparam int SW = avtplc_pkg::SAMPLE_W;
  localparam int WW = avtplc_pkg::WANT_W;
  localparam int KW = avtplc_pkg::LOCK_W;
  localparam int HDR_FIXED = STREAM_HEADER_BYTES + CIP_HEADER_BYTES;
  localparam logic [KW-1:0] LOCK_LEVEL = KW'(LOCK_THRESHOLD);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_EVAL   = 4'b0010,
    ST_DIV    = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // Captured packet fields.
  logic [FW-1:0] frame_r;
  logic          vlan_r, control_r, sv_r, tv_r;
  logic [CW-1:0] dbc_r;
  logic [LW-1:0] dlen_r;
  logic [TW-1:0] ptime_r;

  // Stream state and configuration.
  logic [WW-1:0] wanted_r, wanted_nxt;
  logic [CW-1:0] last_counter_r, last_counter_nxt;
  logic [SW-1:0] prev_samples_r, prev_samples_nxt;
  logic [SW-1:0] pay_ch_r, pay_ch_nxt;
  logic [KW-1:0] lock_r, lock_nxt;

  // Pending result.
  logic                    res_accept_r, res_accept_nxt;
  avtplc_pkg::status_t     res_status_r, res_status_nxt;
  logic                    res_stamp_r, res_stamp_nxt;
  logic [TW-1:0]           res_value_r, res_value_nxt;
  logic [SW-1:0]           res_ch_r, res_ch_nxt;
  logic [SW-1:0]           res_stride_r, res_stride_nxt;
  logic [SW-1:0]           res_samples_r, res_samples_nxt;

  // Output register.
  logic                                 out_valid_r, out_valid_nxt;
  logic [avtplc_pkg::OUT_TDATA_W-1:0]   out_data_r, out_data_nxt;
  logic [avtplc_pkg::OUT_TUSER_W-1:0]   out_user_r, out_user_nxt;

  // Evaluation terms.
  logic [FW-1:0] hdr_len;
  logic          too_short;
  logic [CW-1:0] diff;
  logic [LW-1:0] dlen_off;
  logic [SW-1:0] samples;
  logic          locked;
  logic          stamp;
  logic [SW-1:0] min_ch;
  logic          in_beat;

  avtplc_pkg::div_req_t    div_req;
  avtplc_pkg::div_result_t div_res;

  avtplc_divider u_divider (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (div_req),
    .result (div_res)
  );

  assign in_tready = (state_r == ST_IDLE);
  assign in_beat   = in_tvalid && in_tready;

  // Header length check, counter difference, sample count, lock level, stamp and channel minimum.
  always_comb begin
    hdr_len   = vlan_r ? FW'(avtplc_pkg::VLAN_HDR_BYTES)
                       : FW'(avtplc_pkg::PLAIN_HDR_BYTES);
    too_short = frame_r <= (hdr_len + FW'(HDR_FIXED));
    diff      = dbc_r - last_counter_r;
    dlen_off  = dlen_r - LW'(avtplc_pkg::CIP_DATA_OFFSET);
    samples   = (dlen_r < LW'(avtplc_pkg::CIP_DATA_OFFSET)) ? '0 : dlen_off[LW-1:2];
    locked    = lock_r >= LOCK_LEVEL;
    stamp     = tv_r && (dbc_r[avtplc_pkg::STAMP_PHASE_W-1:0] == '0) && (ptime_r != '0);
    min_ch    = (SW'(wanted_r) < pay_ch_r) ? SW'(wanted_r) : pay_ch_r;
  end

  // Sequencer and state updates.
  always_comb begin
    state_nxt        = state_r;
    wanted_nxt       = cfg_wr_en ? cfg_wr_data : wanted_r;
    last_counter_nxt = last_counter_r;
    prev_samples_nxt = prev_samples_r;
    pay_ch_nxt       = pay_ch_r;
    lock_nxt         = lock_r;
    res_accept_nxt   = res_accept_r;
    res_status_nxt   = res_status_r;
    res_stamp_nxt    = res_stamp_r;
    res_value_nxt    = res_value_r;
    res_ch_nxt       = res_ch_r;
    res_stride_nxt   = res_stride_r;
    res_samples_nxt  = res_samples_r;
    out_valid_nxt    = out_valid_r && !out_tready;
    out_data_nxt     = out_data_r;
    out_user_nxt     = out_user_r;
    div_req.start    = 1'b0;
    div_req.dividend = prev_samples_r;
    div_req.divisor  = diff;

    unique case (state_r)
      ST_IDLE: begin
        if (in_beat) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        // Rejections leave the stream state alone.
        res_accept_nxt  = 1'b0;
        res_stamp_nxt   = 1'b0;
        res_value_nxt   = '0;
        res_ch_nxt      = '0;
        res_stride_nxt  = '0;
        res_samples_nxt = '0;
        state_nxt       = ST_FINISH;
        priority if (too_short) begin
          res_status_nxt = avtplc_pkg::STATUS_TOO_SHORT;
        end else if (control_r) begin
          res_status_nxt = avtplc_pkg::STATUS_CONTROL;
        end else if (!sv_r) begin
          res_status_nxt = avtplc_pkg::STATUS_NO_STREAM;
        end else begin
          last_counter_nxt = dbc_r;
          prev_samples_nxt = samples;
          if (!locked) begin
            res_status_nxt = avtplc_pkg::STATUS_LOCKING;
            if ((prev_samples_r != '0) && (diff != '0)) begin
              div_req.start = 1'b1;
              state_nxt     = ST_DIV;
            end
          end else begin
            res_status_nxt  = avtplc_pkg::STATUS_OK;
            res_accept_nxt  = 1'b1;
            res_stamp_nxt   = stamp;
            res_value_nxt   = stamp ? ptime_r : '0;
            res_ch_nxt      = min_ch;
            res_stride_nxt  = pay_ch_r;
            res_samples_nxt = samples;
          end
        end
      end
      ST_DIV: begin
        // A new or changed channel count restarts the lock run.
        if (div_res.done) begin
          if ((pay_ch_r == '0) || (pay_ch_r != div_res.quotient)) begin
            pay_ch_nxt = div_res.quotient;
            lock_nxt   = KW'(1);
          end else begin
            lock_nxt = lock_r + 1'b1;
          end
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {6'd0, res_samples_r, res_stride_r, res_ch_r, res_value_r};
          out_user_nxt  = {res_stamp_r, res_status_r, res_accept_r};
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      wanted_r       <= '0;
      last_counter_r <= '0;
      prev_samples_r <= '0;
      pay_ch_r       <= '0;
      lock_r         <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      wanted_r       <= wanted_nxt;
      last_counter_r <= last_counter_nxt;
      prev_samples_r <= prev_samples_nxt;
      pay_ch_r       <= pay_ch_nxt;
      lock_r         <= lock_nxt;
      out_valid_r    <= out_valid_nxt;
    end
    res_accept_r  <= res_accept_nxt;
    res_status_r  <= res_status_nxt;
    res_stamp_r   <= res_stamp_nxt;
    res_value_r   <= res_value_nxt;
    res_ch_r      <= res_ch_nxt;
    res_stride_r  <= res_stride_nxt;
    res_samples_r <= res_samples_nxt;
    out_data_r    <= out_data_nxt;
    out_user_r    <= out_user_nxt;
  end

  // Capture the packet fields on the accepted beat.
  always_ff @(posedge clk) begin
    if (in_beat) begin
      frame_r   <= in_tdata[10:0];
      dbc_r     <= in_tdata[18:11];
      dlen_r    <= in_tdata[34:19];
      ptime_r   <= in_tdata[66:35];
      vlan_r    <= in_tuser[0];
      control_r <= in_tuser[1];
      sv_r      <= in_tuser[2];
      tv_r      <= in_tuser[3];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

@@ sv/avtplc_checker.sv @@
`include "assert_macros.svh"

module avtplc_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tvalid,
  input logic                               in_tready,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [avtplc_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [avtplc_pkg::OUT_TUSER_W-1:0] out_tuser
);

  // Views of the result beat used by the checks below.
  logic                                                        out_ok;
  logic                                                        out_stall;
  logic [avtplc_pkg::OUT_TUSER_W+avtplc_pkg::OUT_TDATA_W-1:0] out_beat;

  assign out_ok    = (out_tuser[3:1] == avtplc_pkg::STATUS_OK);
  assign out_stall = out_tvalid && !out_tready;
  assign out_beat  = {out_tuser, out_tdata};

  // A packet under evaluation holds off the next input beat.
  `ASSERT_NEXT(a_busy_after_beat, clk, rst_n, in_tvalid && in_tready, !in_tready)

  // Results without samples carry an empty payload.
  `ASSERT_IMPLY(a_reject_empty, clk, rst_n, out_tvalid && !out_tuser[0], out_tdata == '0)

  // Delivery goes with the ok status and with nothing else.
  `ASSERT_IMPLY(a_accept_is_ok, clk, rst_n, out_tvalid, out_tuser[0] == out_ok)

  // A stalled result beat holds.
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_tvalid && $stable(out_beat))

endmodule

bind avtp_listener_packet_check avtplc_checker u_checker (.*);

@@ test/tb_avtp_listener_packet_check.sv @@
`timescale 1ns / 1ps

module tb_avtp_listener_packet_check;

  localparam int STREAM_HEADER_BYTES = 24;
  localparam int CIP_HEADER_BYTES    = 8;
  localparam int LOCK_THRESHOLD      = 10;

  // Cycles without any beat on either channel before the run is abandoned.
  localparam int STALL_LIMIT = 3000;
  // One long receiver hold-off, started once this many results have arrived.
  localparam int HOLD_AT     = 200;
  localparam int HOLD_CYCLES = 400;
  // Quiet cycles allowed at the very end for a late, unexpected beat.
  localparam int TAIL_CYCLES = 40;

  // Header summary of one received packet.
  typedef struct packed {
    logic [avtplc_pkg::FRAME_W-1:0]   frame_bytes;
    logic                             vlan;
    logic                             control;
    logic                             sv;
    logic                             tv;
    logic [avtplc_pkg::COUNTER_W-1:0] counter;
    logic [avtplc_pkg::LEN_W-1:0]     dlen;
    logic [avtplc_pkg::TIME_W-1:0]    ptime;
  } packet_t;

  // Verdict for one packet.
  typedef struct packed {
    logic                            accepted;
    avtplc_pkg::status_t             status;
    logic                            stamp_now;
    logic [avtplc_pkg::TIME_W-1:0]   stamp_value;
    logic [avtplc_pkg::SAMPLE_W-1:0] push_channels;
    logic [avtplc_pkg::SAMPLE_W-1:0] push_stride;
    logic [avtplc_pkg::SAMPLE_W-1:0] push_samples;
  } outcome_t;

  // Tracks the listener's lock state and holds the verdicts still due.
  class outcome_board;
    logic [avtplc_pkg::WANT_W-1:0]    wanted;
    logic [avtplc_pkg::COUNTER_W-1:0] last_counter;
    logic [avtplc_pkg::SAMPLE_W-1:0]  previous_samples;
    logic [avtplc_pkg::SAMPLE_W-1:0]  payload_channels;
    logic [avtplc_pkg::LOCK_W-1:0]    lock_count;
    outcome_t                         outcomes_due[$];
    int                               errors;
    int                               n_checked;
    int                               n_delivered;
    int                               n_stamped;
    int                               n_locking;

    function new();
      wanted           = '0;
      last_counter     = '0;
      previous_samples = '0;
      payload_channels = '0;
      lock_count       = '0;
      errors           = 0;
      n_checked        = 0;
      n_delivered      = 0;
      n_stamped        = 0;
      n_locking        = 0;
    endfunction

    function int pending();
      return outcomes_due.size();
    endfunction

    // Works out the verdict for an accepted packet and updates the lock state.
    function void note_packet(packet_t p);
      outcome_t                         due;
      int unsigned                      hdr;
      logic [avtplc_pkg::COUNTER_W-1:0] diff;
      logic [avtplc_pkg::LEN_W-1:0]     len_less;
      logic [avtplc_pkg::SAMPLE_W-1:0]  samples;
      logic [avtplc_pkg::SAMPLE_W-1:0]  prev;
      logic [avtplc_pkg::SAMPLE_W-1:0]  nch;
      logic                             stamp;
      due = '0;
      hdr = p.vlan ? avtplc_pkg::VLAN_HDR_BYTES : avtplc_pkg::PLAIN_HDR_BYTES;
      if (p.frame_bytes <= hdr + STREAM_HEADER_BYTES + CIP_HEADER_BYTES) begin
        due.status = avtplc_pkg::STATUS_TOO_SHORT;
      end else if (p.control) begin
        due.status = avtplc_pkg::STATUS_CONTROL;
      end else if (!p.sv) begin
        due.status = avtplc_pkg::STATUS_NO_STREAM;
      end else begin
        diff = p.counter - last_counter;
        last_counter = p.counter;
        len_less = p.dlen - 16'd8;
        samples = (p.dlen < 16'd8) ? '0 : len_less[15:2];
        prev = previous_samples;
        previous_samples = samples;
        if (lock_count < LOCK_THRESHOLD) begin
          // Channel inference only works with a sample count and a counter step.
          if (prev != 0 && diff != 0) begin
            nch = prev / diff;
            if (payload_channels == 0 || payload_channels != nch) begin
              payload_channels = nch;
              lock_count = '0;
            end
            lock_count = lock_count + 1'b1;
          end
          due.status = avtplc_pkg::STATUS_LOCKING;
        end else begin
          stamp = p.tv && (p.counter[2:0] == 3'd0) && (p.ptime != 0);
          due.accepted      = 1'b1;
          due.status        = avtplc_pkg::STATUS_OK;
          due.stamp_now     = stamp;
          due.stamp_value   = stamp ? p.ptime : '0;
          due.push_channels = (wanted < payload_channels) ? {7'd0, wanted}
                                                          : payload_channels;
          due.push_stride   = payload_channels;
          due.push_samples  = samples;
        end
      end
      outcomes_due.push_back(due);
    endfunction

    // Prints one line per failure and counts it.
    task report(string msg);
      errors++;
      $display("ERROR: %s", msg);
    endtask

    task compare_field(string name, longint unsigned got, longint unsigned want);
      if (got !== want)
        report($sformatf("result %0d: %s is %0h, expected %0h", n_checked, name, got, want));
    endtask

    // Compares a received verdict with the oldest one due.
    task check_result(outcome_t got);
      outcome_t due;
      if (outcomes_due.size() == 0) begin
        report($sformatf("result beat %0d arrived with nothing due", n_checked));
      end else begin
        due = outcomes_due.pop_front();
        compare_field("accepted", got.accepted, due.accepted);
        compare_field("status", got.status, due.status);
        compare_field("stamp_now", got.stamp_now, due.stamp_now);
        compare_field("stamp_value", got.stamp_value, due.stamp_value);
        compare_field("push_channels", got.push_channels, due.push_channels);
        compare_field("push_stride", got.push_stride, due.push_stride);
        compare_field("push_samples", got.push_samples, due.push_samples);
        if (due.accepted) n_delivered++;
        if (due.stamp_now) n_stamped++;
        if (due.status == avtplc_pkg::STATUS_LOCKING) n_locking++;
      end
      n_checked++;
    endtask
  endclass

  logic                               clk;
  logic                               rst_n;
  logic                               cfg_wr_en;
  logic [avtplc_pkg::WANT_W-1:0]      cfg_wr_data;
  logic                               in_tvalid;
  logic                               in_tready;
  logic [avtplc_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic [avtplc_pkg::IN_TUSER_W-1:0]  in_tuser;
  logic                               out_tvalid;
  logic                               out_tready;
  logic [avtplc_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic [avtplc_pkg::OUT_TUSER_W-1:0] out_tuser;

  outcome_board board;
  int           send_idle_pct;
  int           recv_idle_pct;
  int           rx_count;
  int           tx_count;
  int           hold_left;
  bit           hold_done;
  int           quiet_cycles;

  avtp_listener_packet_check #(
    .STREAM_HEADER_BYTES(STREAM_HEADER_BYTES),
    .CIP_HEADER_BYTES   (CIP_HEADER_BYTES),
    .LOCK_THRESHOLD     (LOCK_THRESHOLD)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Builds an ordinary data packet on a plain frame of ample length.
  function automatic packet_t data_packet(logic [avtplc_pkg::COUNTER_W-1:0] counter,
                                          logic [avtplc_pkg::LEN_W-1:0] dlen, logic tv,
                                          logic [avtplc_pkg::TIME_W-1:0] ptime);
    packet_t p;
    p = '0;
    p.frame_bytes = 11'd100;
    p.sv          = 1'b1;
    p.tv          = tv;
    p.counter     = counter;
    p.dlen        = dlen;
    p.ptime       = ptime;
    return p;
  endfunction

  // Mostly well-formed data packets; the rest are noise or near the length limit.
  function automatic packet_t random_packet();
    packet_t     p;
    int unsigned hdr;
    int unsigned pick;
    int unsigned min_ok;
    p = '0;
    pick = $urandom_range(99);
    p.vlan = 1'($urandom_range(1));
    hdr = p.vlan ? avtplc_pkg::VLAN_HDR_BYTES : avtplc_pkg::PLAIN_HDR_BYTES;
    min_ok = hdr + STREAM_HEADER_BYTES + CIP_HEADER_BYTES + 1;
    if (pick < 80) begin
      p.frame_bytes = 11'($urandom_range(2047, min_ok));
      p.sv = 1'b1;
      p.tv = ($urandom_range(3) != 0);
    end else begin
      if (pick < 86)
        p.frame_bytes = 11'(min_ok - 1 + $urandom_range(1));
      else
        p.frame_bytes = 11'($urandom_range(2047));
      p.control = 1'($urandom_range(1));
      p.sv      = 1'($urandom_range(1));
      p.tv      = 1'($urandom_range(1));
    end
    // Aligned counters make timestamp beats common.
    if ($urandom_range(1) == 0)
      p.counter = {5'($urandom), 3'd0};
    else
      p.counter = 8'($urandom);
    case ($urandom_range(7))
      0:       p.dlen = 16'($urandom_range(15));
      1:       p.dlen = '1;
      default: p.dlen = 16'($urandom);
    endcase
    case ($urandom_range(9))
      0:       p.ptime = '0;
      1:       p.ptime = '1;
      default: p.ptime = $urandom;
    endcase
    return p;
  endfunction

  // Offers one packet, with a random gap first, and waits for the beat.
  task automatic send_item(packet_t p);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tdata  = {5'd0, p.ptime, p.dlen, p.counter, p.frame_bytes};
    in_tuser  = {p.tv, p.sv, p.control, p.vlan};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    board.note_packet(p);
    tx_count++;
  endtask

  // Stops offering and waits until every verdict due has arrived.
  task automatic drain();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  task automatic write_wanted(logic [avtplc_pkg::WANT_W-1:0] value);
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    board.wanted = value;
  endtask

  task automatic set_idling(int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  task automatic run_random(int count);
    repeat (count) send_item(random_packet());
  endtask

  // Boundaries of the rejection checks, then the whole locking sequence and locked packets.
  task automatic run_directed();
    packet_t                          p;
    logic [avtplc_pkg::COUNTER_W-1:0] dbc;
    // Every rejection at once on an empty frame: length is checked first.
    p = '0;
    p.control = 1'b1;
    p.tv      = 1'b1;
    p.counter = '1;
    p.dlen    = '1;
    p.ptime   = '1;
    send_item(p);
    // Frames one byte short of the minimum length, plain and tagged, then just long enough.
    p = data_packet(8'd0, 16'd200, 1'b1, 32'd1);
    p.frame_bytes = 11'(avtplc_pkg::PLAIN_HDR_BYTES + STREAM_HEADER_BYTES + CIP_HEADER_BYTES);
    send_item(p);
    p.vlan = 1'b1;
    p.frame_bytes = 11'(avtplc_pkg::VLAN_HDR_BYTES + STREAM_HEADER_BYTES + CIP_HEADER_BYTES);
    send_item(p);
    p.frame_bytes = p.frame_bytes + 1'b1;
    p.control = 1'b1;
    send_item(p);
    p.vlan = 1'b0;
    p.frame_bytes = 11'(avtplc_pkg::PLAIN_HDR_BYTES + STREAM_HEADER_BYTES
                        + CIP_HEADER_BYTES + 1);
    p.control = 1'b0;
    p.sv = 1'b0;
    send_item(p);
    // No previous samples, a short data length and a zero counter step.
    send_item(data_packet(8'd0, 16'd0, 1'b1, 32'd3));
    send_item(data_packet(8'd0, 16'd7, 1'b1, 32'd3));
    send_item(data_packet(8'd0, 16'd200, 1'b1, 32'd3));
    send_item(data_packet(8'd0, 16'd200, 1'b1, 32'd3));
    // A step larger than the sample count infers zero channels.
    send_item(data_packet(8'd200, 16'd200, 1'b1, 32'd3));
    send_item(data_packet(8'd206, 16'd200, 1'b1, 32'd3));
    // A different step restarts the lock.
    send_item(data_packet(8'd210, 16'd200, 1'b1, 32'd3));
    dbc = 8'd210;
    repeat (LOCK_THRESHOLD) begin
      dbc = dbc + 8'd6;
      send_item(data_packet(dbc, 16'd200, 1'b1, $urandom));
    end
    // Locked: largest payload and timestamp, the cases without a stamp, then a rejection.
    send_item(data_packet(8'd16, 16'hFFFF, 1'b1, 32'hFFFF_FFFF));
    send_item(data_packet(8'd24, 16'd3, 1'b1, 32'd0));
    send_item(data_packet(8'd25, 16'd200, 1'b1, 32'd1));
    send_item(data_packet(8'd32, 16'd200, 1'b0, 32'd5));
    p = data_packet(8'd40, 16'd200, 1'b1, 32'd7);
    p.frame_bytes = '1;
    p.vlan = 1'b1;
    p.sv = 1'b0;
    send_item(p);
  endtask

  // Receiver: random stalls, plus one long hold-off while the sender keeps offering.
  initial begin
    out_tready = 1'b0;
    hold_left  = 0;
    hold_done  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_tready = 1'b0;
        hold_left--;
      end else if (!hold_done && rx_count >= HOLD_AT) begin
        hold_done  = 1'b1;
        hold_left  = HOLD_CYCLES - 1;
        out_tready = 1'b0;
      end else begin
        out_tready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Result beats are checked as they are taken.
  always @(posedge clk) begin
    outcome_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.accepted      = out_tuser[0];
      got.status        = avtplc_pkg::status_t'(out_tuser[3:1]);
      got.stamp_now     = out_tuser[4];
      got.stamp_value   = out_tdata[31:0];
      got.push_channels = out_tdata[45:32];
      got.push_stride   = out_tdata[59:46];
      got.push_samples  = out_tdata[73:60];
      board.check_result(got);
      rx_count++;
    end
  end

  // Watchdog on cycles in which neither channel moves a beat.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no beat for %0d cycles", STALL_LIMIT);
      $display("tb_avtp_listener_packet_check: done, errors");
      $finish;
    end
  end

  initial begin
    board        = new();
    rst_n        = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = '0;
    tx_count     = 0;
    set_idling(12, 69);
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    write_wanted(7'd5);
    run_directed();

    // Sender mostly busy, receiver mostly stalling; the long hold-off falls here.
    drain();
    set_idling(12, 69);
    write_wanted(7'd64);
    run_random(500);

    // Sender mostly idle, receiver mostly ready.
    drain();
    set_idling(69, 12);
    write_wanted(7'd0);
    run_random(500);

    // No idling on either side, with a full pause and a new setting midway.
    drain();
    set_idling(0, 0);
    write_wanted(7'd127);
    run_random(250);
    drain();
    write_wanted(7'($urandom_range(127)));
    run_random(250);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.pending() != 0)
      board.report($sformatf("%0d verdicts never arrived", board.pending()));

    $display("summary: %0d packets sent, %0d verdicts checked, %0d while locking",
             tx_count, board.n_checked, board.n_locking);
    $display("summary: %0d delivered samples, %0d registered a timestamp, %0d mismatches",
             board.n_delivered, board.n_stamped, board.errors);
    if (board.errors == 0) begin
      $display("tb_avtp_listener_packet_check: done, clean");
    end else begin
      $display("tb_avtp_listener_packet_check: done, errors");
    end
    $finish;
  end

endmodule

@@ avtp_listener_packet_check.f @@
+incdir+sv
sv/avtplc_pkg.sv
sv/avtplc_divider.sv
sv/avtp_listener_packet_check.sv
sv/avtplc_checker.sv
test/tb_avtp_listener_packet_check.sv
